FILE: hdl/ptba_pkg.sv
// shared types, constants and codes for the power-of-two block allocator
// no dependencies
`timescale 1ns / 1ps

package ptba_pkg;

    // table and pool geometry
    localparam int MAX_ENTRIES = 256;
    localparam int POOL_ORDER  = 10;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ORD_W       = $clog2(POOL_ORDER + 1);
    localparam int NHIST       = POOL_ORDER + 1;
    localparam int SIZE_W      = POOL_ORDER + 1;

    // stream field widths
    localparam int OWN_W   = 8;
    localparam int AMT_W   = 12;
    localparam int ST_W    = 2;
    localparam int GRANT_W = 11;
    localparam int FRAG_W  = 10;
    localparam int TOT_W   = 9;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NOOWNER = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // table entry, block size kept as its order
    typedef struct packed {
        logic             free;
        logic [OWN_W-1:0] owner;
        logic [ORD_W-1:0] ord;
    } t_entry;

    typedef enum logic [1:0] {
        SC_ALLOC = 2'd0,
        SC_REL   = 2'd1,
        SC_MERGE = 2'd2,
        SC_SHIFT = 2'd3
    } t_scan;

    typedef enum logic [2:0] {
        WS_NONE   = 3'd0,
        WS_INIT   = 3'd1,
        WS_EXACT  = 3'd2,
        WS_SPLIT  = 3'd3,
        WS_APPEND = 3'd4,
        WS_PIECE  = 3'd5,
        WS_HIT    = 3'd6,
        WS_MERGE  = 3'd7
    } t_wsel;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    scan_go;
        t_scan   scan_mode;
        t_wsel   wsel;
        logic    cnt_add;
        logic    cnt_dec;
        logic    res_go;
        t_status code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic too_big;
        logic scan_done;
        logic best_vld;
        logic exact;
        logic overflow;
        logic any_dup;
        logic npc_zero;
        logic out_busy;
    } t_stat;

endpackage

FILE: hdl/ptba_dp.sv
// allocator datapath: entry table memory, scan engine, histogram, result register
// depends on ptba_pkg
`timescale 1ns / 1ps

module ptba_dp import ptba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic             i_func,
    input  logic [OWN_W-1:0] i_owner,
    input  logic [AMT_W-1:0] i_amount,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata
);

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd;

    logic             r_func;
    logic [OWN_W-1:0] r_owner;
    logic [AMT_W-1:0] r_amount;
    logic [ORD_W-1:0] r_bs_ord;
    logic [CNT_W-1:0] r_count;

    logic             r_scan_on, r_dv;
    t_scan            r_mode;
    logic [CNT_W-1:0] r_rptr, r_didx;

    logic             r_best_vld, r_j_vld;
    logic [IDX_W-1:0] r_best_idx;
    logic [ORD_W-1:0] r_best_ord;
    logic [CNT_W-1:0] r_j_idx;
    logic [ORD_W-1:0] r_gr_ord;

    logic [CNT_W-1:0] r_wptr;
    logic [ORD_W-1:0] r_pord, r_npc;
    logic [CNT_W-1:0] r_hist [NHIST];

    logic             r_ovalid;
    logic [OUT_W-1:0] r_odata;

    logic             rd_en, we;
    logic [IDX_W-1:0] waddr;
    t_entry           wdata;
    logic [CNT_W-1:0] shift_dst;
    logic [ORD_W-1:0] in_ord, need;
    logic [2**ORD_W-1:0] dup;
    logic [CNT_W:0]   need_sum;

    // round the incoming amount up to a power-of-two order
    always_comb begin
        in_ord = ORD_W'(POOL_ORDER);
        for (int o = POOL_ORDER; o >= 0; o--) begin
            if ((AMT_W'(1) << o) >= i_amount) begin
                in_ord = ORD_W'(o);
            end
        end
    end

    // orders that hold two or more free blocks
    always_comb begin
        dup = '0;
        for (int o = 0; o < NHIST; o++) begin
            dup[o] = (r_hist[o] >= CNT_W'(2));
        end
    end

    assign need     = r_best_ord - r_bs_ord;
    assign need_sum = {1'b0, r_count} + (CNT_W + 1)'(need);
    assign rd_en    = r_scan_on && (r_rptr < r_count);
    assign shift_dst = r_didx - CNT_W'(1);

    // status toward the controller
    always_comb begin
        o_stat.func      = r_func;
        o_stat.too_big   = (r_amount > AMT_W'(1 << POOL_ORDER));
        o_stat.scan_done = r_scan_on && !rd_en && !r_dv;
        o_stat.best_vld  = r_best_vld;
        o_stat.exact     = (r_best_ord == r_bs_ord);
        o_stat.overflow  = need_sum > (CNT_W + 1)'(MAX_ENTRIES);
        o_stat.any_dup   = |dup;
        o_stat.npc_zero  = (r_npc == '0);
        o_stat.out_busy  = r_ovalid && !i_m_tready;
    end

    // table write port select
    always_comb begin
        we    = 1'b1;
        waddr = r_best_idx;
        wdata = '{free: 1'b1, owner: '0, ord: r_best_ord};
        unique case (i_cmd.wsel)
            WS_NONE: begin
                we    = r_scan_on && r_dv && (r_mode == SC_SHIFT);
                waddr = shift_dst[IDX_W-1:0];
                wdata = r_rd;
            end
            WS_INIT: begin
                waddr = '0;
                wdata = '{free: 1'b1, owner: '0, ord: ORD_W'(POOL_ORDER)};
            end
            WS_EXACT:  wdata = '{free: 1'b0, owner: r_owner, ord: r_bs_ord};
            WS_SPLIT:  wdata = '{free: 1'b1, owner: '0, ord: r_best_ord - ORD_W'(1)};
            WS_APPEND: begin
                waddr = r_count[IDX_W-1:0];
                wdata = '{free: 1'b0, owner: r_owner, ord: r_bs_ord};
            end
            WS_PIECE: begin
                waddr = r_wptr[IDX_W-1:0];
                wdata = '{free: 1'b1, owner: '0, ord: r_pord};
            end
            WS_HIT:    wdata = '{free: 1'b1, owner: '0, ord: r_best_ord};
            WS_MERGE:  wdata = '{free: 1'b1, owner: '0, ord: r_best_ord + ORD_W'(1)};
            default:   we = 1'b0;
        endcase
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd <= r_mem[r_rptr[IDX_W-1:0]];
        end
    end

    // operand capture and split bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_owner  <= i_owner;
            r_amount <= i_amount;
            r_bs_ord <= in_ord;
        end
        if (i_cmd.wsel == WS_SPLIT) begin
            r_wptr <= r_count + CNT_W'(1);
            r_pord <= r_best_ord - ORD_W'(2);
            r_npc  <= r_best_ord - ORD_W'(1) - r_bs_ord;
        end else if (i_cmd.wsel == WS_PIECE) begin
            r_wptr <= r_wptr + CNT_W'(1);
            r_pord <= r_pord - ORD_W'(1);
            r_npc  <= r_npc - ORD_W'(1);
        end
        if (i_cmd.wsel == WS_HIT) begin
            r_gr_ord <= r_best_ord;
        end
    end

    // scan engine with search and histogram per mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_dv      <= 1'b0;
            r_count   <= CNT_W'(1);
        end else begin
            if (i_cmd.scan_go) begin
                r_scan_on  <= 1'b1;
                r_dv       <= 1'b0;
                r_mode     <= i_cmd.scan_mode;
                r_rptr     <= (i_cmd.scan_mode == SC_SHIFT) ? r_j_idx + CNT_W'(1) : '0;
                r_best_vld <= (i_cmd.scan_mode == SC_SHIFT) ? r_best_vld : 1'b0;
                r_j_vld    <= 1'b0;
                if (i_cmd.scan_mode == SC_REL) begin
                    for (int o = 0; o < NHIST; o++) begin
                        r_hist[o] <= '0;
                    end
                end
            end else if (r_scan_on) begin
                r_dv   <= rd_en;
                r_didx <= r_rptr;
                if (rd_en) begin
                    r_rptr <= r_rptr + CNT_W'(1);
                end
                if (o_stat.scan_done) begin
                    r_scan_on <= 1'b0;
                end
                if (r_dv) begin
                    case (r_mode)
                        SC_ALLOC: begin
                            if (r_rd.free && r_rd.ord >= r_bs_ord &&
                                (!r_best_vld || r_rd.ord < r_best_ord)) begin
                                r_best_vld <= 1'b1;
                                r_best_idx <= r_didx[IDX_W-1:0];
                                r_best_ord <= r_rd.ord;
                            end
                        end
                        SC_REL: begin
                            if (r_rd.free) begin
                                for (int o = 0; o < NHIST; o++) begin
                                    if (ORD_W'(o) == r_rd.ord) begin
                                        r_hist[o] <= r_hist[o] + CNT_W'(1);
                                    end
                                end
                            end else if (r_rd.owner == r_owner && !r_best_vld) begin
                                r_best_vld <= 1'b1;
                                r_best_idx <= r_didx[IDX_W-1:0];
                                r_best_ord <= r_rd.ord;
                            end
                        end
                        SC_MERGE: begin
                            if (r_rd.free) begin
                                if (!r_best_vld && dup[r_rd.ord]) begin
                                    r_best_vld <= 1'b1;
                                    r_best_idx <= r_didx[IDX_W-1:0];
                                    r_best_ord <= r_rd.ord;
                                end else if (r_best_vld && !r_j_vld &&
                                             r_rd.ord == r_best_ord) begin
                                    r_j_vld <= 1'b1;
                                    r_j_idx <= r_didx;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // histogram upkeep on a freed block or a merged pair
            if (i_cmd.wsel == WS_HIT) begin
                for (int o = 0; o < NHIST; o++) begin
                    if (ORD_W'(o) == r_best_ord) begin
                        r_hist[o] <= r_hist[o] + CNT_W'(1);
                    end
                end
            end else if (i_cmd.wsel == WS_MERGE) begin
                for (int o = 0; o < NHIST; o++) begin
                    if (ORD_W'(o) == r_best_ord) begin
                        r_hist[o] <= r_hist[o] - CNT_W'(2);
                    end else if (ORD_W'(o) == r_best_ord + ORD_W'(1)) begin
                        r_hist[o] <= r_hist[o] + CNT_W'(1);
                    end
                end
            end
            // entry count
            if (i_cmd.cnt_add) begin
                r_count <= need_sum[CNT_W-1:0];
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.res_go) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [GRANT_W-1:0] gr;
        logic [FRAG_W-1:0]  fr;
        gr = '0;
        fr = '0;
        if (i_cmd.code == ST_OK) begin
            if (r_func) begin
                gr = GRANT_W'(1) << r_gr_ord;
            end else begin
                gr = GRANT_W'(1) << r_bs_ord;
                fr = FRAG_W'(gr - r_amount[GRANT_W-1:0]);
            end
        end
        if (i_cmd.res_go) begin
            r_odata <= {TOT_W'(r_count), fr, gr, i_cmd.code};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(MAX_ENTRIES)) && (r_count != '0))
        else $error("entry count out of range");

    a_read_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_didx < r_count))
        else $error("scan read beyond table end");

    a_shift_has_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan_on && r_mode == SC_SHIFT) |-> (r_count >= CNT_W'(2)))
        else $error("entry removal without a merged pair");

endmodule

FILE: hdl/ptba_ctrl.sv
// allocator sequencer: one-hot state machine issuing datapath commands
// depends on ptba_pkg
`timescale 1ns / 1ps

module ptba_ctrl import ptba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [13:0] {
        S_INIT  = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_DEC   = 14'b00000000000100,
        S_ASCAN = 14'b00000000001000,
        S_AEVAL = 14'b00000000010000,
        S_WA    = 14'b00000000100000,
        S_WP    = 14'b00000001000000,
        S_RSCAN = 14'b00000010000000,
        S_REVAL = 14'b00000100000000,
        S_MCHK  = 14'b00001000000000,
        S_MSCAN = 14'b00010000000000,
        S_MWR   = 14'b00100000000000,
        S_SHIFT = 14'b01000000000000,
        S_RES   = 14'b10000000000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_code          = r_code;
        o_cmd           = '0;
        o_cmd.scan_mode = SC_ALLOC;
        o_cmd.wsel      = WS_NONE;
        o_cmd.code      = r_code;
        o_s_tready      = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wsel = WS_INIT;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.func) begin
                    o_cmd.scan_go   = 1'b1;
                    o_cmd.scan_mode = SC_REL;
                    n_state         = S_RSCAN;
                end else if (i_stat.too_big) begin
                    n_code  = ST_NOSPACE;
                    n_state = S_RES;
                end else begin
                    o_cmd.scan_go = 1'b1;
                    n_state       = S_ASCAN;
                end
            end
            S_ASCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_AEVAL;
                end
            end
            S_AEVAL: begin
                if (!i_stat.best_vld) begin
                    n_code  = ST_NOSPACE;
                    n_state = S_RES;
                end else if (i_stat.exact) begin
                    o_cmd.wsel = WS_EXACT;
                    n_code     = ST_OK;
                    n_state    = S_RES;
                end else if (i_stat.overflow) begin
                    n_code  = ST_FULL;
                    n_state = S_RES;
                end else begin
                    o_cmd.wsel = WS_SPLIT;
                    n_state    = S_WA;
                end
            end
            S_WA: begin
                o_cmd.wsel = WS_APPEND;
                n_state    = S_WP;
            end
            S_WP: begin
                if (!i_stat.npc_zero) begin
                    o_cmd.wsel = WS_PIECE;
                end else begin
                    o_cmd.cnt_add = 1'b1;
                    n_code        = ST_OK;
                    n_state       = S_RES;
                end
            end
            S_RSCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_REVAL;
                end
            end
            S_REVAL: begin
                if (!i_stat.best_vld) begin
                    n_code  = ST_NOOWNER;
                    n_state = S_RES;
                end else begin
                    o_cmd.wsel = WS_HIT;
                    n_state    = S_MCHK;
                end
            end
            S_MCHK: begin
                if (i_stat.any_dup) begin
                    o_cmd.scan_go   = 1'b1;
                    o_cmd.scan_mode = SC_MERGE;
                    n_state         = S_MSCAN;
                end else begin
                    n_code  = ST_OK;
                    n_state = S_RES;
                end
            end
            S_MSCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_MWR;
                end
            end
            S_MWR: begin
                o_cmd.wsel      = WS_MERGE;
                o_cmd.scan_go   = 1'b1;
                o_cmd.scan_mode = SC_SHIFT;
                n_state         = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.scan_done) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_MCHK;
                end
            end
            S_RES: begin
                if (!i_stat.out_busy) begin
                    o_cmd.res_go = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule

FILE: hdl/power_of_two_block_allocator.sv
// an exact fit, a failed search or a failed release takes one serial scan of the table entries;
// a split adds the append and one write per split piece; an amount above the pool skips the
// scan; a release adds a merge scan and an entry shift scan per merge; a stalled result holds it
// throughput: one item at a time; the next item is taken once the result is registered
// reset: synchronous active-low; the cycle after reset writes the whole-pool entry, ready low
// top level: stream ports, sequencer and datapath; depends on ptba_pkg, ptba_ctrl, ptba_dp
`timescale 1ns / 1ps

module power_of_two_block_allocator import ptba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,  // owner_id[7:0], amount[19:8], zero pad
    input  logic             i_s_tuser,  // func
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata   // status[1:0], granted_size[12:2],
                                         // internal_frag[22:13], entry_total[31:23]
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    ptba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table and result datapath
    ptba_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_func     (i_s_tuser),
        .i_owner    (i_s_tdata[OWN_W-1:0]),
        .i_amount   (i_s_tdata[OWN_W+AMT_W-1:OWN_W]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

FILE: tb/sv/tb.sv
// testbench for the power-of-two block allocator: random and directed requests
// and releases, each result checked against an in-bench allocation table model
// depends on ptba_pkg and power_of_two_block_allocator
`timescale 1ns / 1ps

module tb;
    import ptba_pkg::*;

    localparam int POOL = 1 << POOL_ORDER;
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    // packed from the top bit down, so status lands in the lowest bits
    typedef struct packed {
        logic [TOT_W-1:0]    total;
        logic [FRAG_W-1:0]   frag;
        logic [GRANT_W-1:0]  granted;
        t_status             status;
    } t_grant;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata = '0;
    logic             i_s_tuser = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    power_of_two_block_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // allocation table model
    int   blk_size [MAX_ENTRIES];
    bit   blk_free [MAX_ENTRIES];
    logic [7:0] blk_owner [MAX_ENTRIES];
    int   blk_count;

    t_grant grant_q[$];
    int  errors = 0;
    int  n_sent = 0, n_got = 0, n_fail_codes = 0;
    bit  idle_en = 1'b1;
    longint cycles = 0;

    function automatic void table_reset();
        blk_size[0] = POOL;
        blk_free[0] = 1'b1;
        blk_owner[0] = '0;
        blk_count = 1;
    endfunction

    function automatic void table_drop(int idx);
        for (int k = idx; k + 1 < blk_count; k++) begin
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
            blk_owner[k] = blk_owner[k+1];
        end
        blk_count--;
    endfunction

    function automatic void table_append(int sz, bit fr, logic [7:0] own);
        blk_size[blk_count] = sz;
        blk_free[blk_count] = fr;
        blk_owner[blk_count] = own;
        blk_count++;
    endfunction

    // merge equal free blocks until none remain, regardless of adjacency
    function automatic void table_coalesce();
        bit merged;
        merged = 1'b1;
        while (merged) begin
            merged = 1'b0;
            for (int i = 0; i < blk_count && !merged; i++) begin
                if (!blk_free[i]) continue;
                for (int j = 0; j < blk_count; j++) begin
                    if (j != i && blk_free[j] && blk_size[j] == blk_size[i]) begin
                        blk_size[i] = blk_size[i] * 2;
                        table_drop(j);
                        merged = 1'b1;
                        break;
                    end
                end
            end
        end
    endfunction

    function automatic t_grant allocate_or_free(logic fn, logic [7:0] own, int amt);
        t_grant r;
        int bs, best, rem, need, hit;
        bit first;
        r = '{total: '0, frag: '0, granted: '0, status: ST_OK};
        if (fn == FN_ALLOC) begin
            if (amt > POOL) begin
                r.status = ST_NOSPACE;
            end else begin
                bs = 1;
                best = -1;
                while (bs < amt) bs = bs * 2;
                for (int i = 0; i < blk_count; i++)
                    if (blk_free[i] && blk_size[i] >= bs &&
                        (best < 0 || blk_size[i] < blk_size[best]))
                        best = i;
                if (best < 0) begin
                    r.status = ST_NOSPACE;
                end else if (blk_size[best] == bs) begin
                    blk_free[best] = 1'b0;
                    blk_owner[best] = own;
                    r.granted = GRANT_W'(bs);
                    r.frag = FRAG_W'(bs - amt);
                end else begin
                    rem = blk_size[best] - bs;
                    need = $countones(rem);
                    if (blk_count + need > MAX_ENTRIES) begin
                        r.status = ST_FULL;
                    end else begin
                        first = 1'b1;
                        table_append(bs, 1'b0, own);
                        for (int b = POOL; b != 0; b = b / 2) begin
                            if ((rem & b) == 0) continue;
                            if (first) begin
                                blk_size[best] = b;
                                first = 1'b0;
                            end else begin
                                table_append(b, 1'b1, '0);
                            end
                        end
                        r.granted = GRANT_W'(bs);
                        r.frag = FRAG_W'(bs - amt);
                    end
                end
            end
        end else begin
            hit = -1;
            for (int i = 0; i < blk_count; i++)
                if (!blk_free[i] && blk_owner[i] == own) begin
                    hit = i;
                    break;
                end
            if (hit < 0) begin
                r.status = ST_NOOWNER;
            end else begin
                blk_free[hit] = 1'b1;
                blk_owner[hit] = '0;
                r.granted = GRANT_W'(blk_size[hit]);
                table_coalesce();
            end
        end
        r.total = TOT_W'(blk_count);
        return r;
    endfunction

    function automatic bit roll_idle();
        return idle_en && ($urandom_range(99) < 27);
    endfunction

    // send one request or release transfer, predicting its result on acceptance
    task automatic send_op(logic fn, logic [7:0] own, int amt);
        if (roll_idle()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while (roll_idle()) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= fn;
        i_s_tdata <= {4'b0, amt[AMT_W-1:0], own};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        grant_q.push_back(allocate_or_free(fn, own, amt));
        n_sent++;
    endtask

    // result side: random stalls, field-by-field compare
    always @(posedge i_clk) begin
        t_grant act, exp_r;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                act = o_m_tdata;
                n_got++;
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_m_tdata);
                    errors++;
                end else begin
                    exp_r = grant_q.pop_front();
                    if (act.status != ST_OK) n_fail_codes++;
                    if (act.status != exp_r.status) begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status, act.status);
                        errors++;
                    end
                    if (act.granted != exp_r.granted) begin
                        $display("%0t: granted exp %0d got %0d", $time, exp_r.granted,
                                 act.granted);
                        errors++;
                    end
                    if (act.frag != exp_r.frag) begin
                        $display("%0t: frag exp %0d got %0d", $time, exp_r.frag, act.frag);
                        errors++;
                    end
                    if (act.total != exp_r.total) begin
                        $display("%0t: total exp %0d got %0d", $time, exp_r.total, act.total);
                        errors++;
                    end
                end
            end
            i_m_tready <= !roll_idle();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[power_of_two_block_allocator] ERROR");
            $finish;
        end
    end

    task automatic test_edges();
        send_op(FN_FREE, 8'd0, 0);          // unknown owner on empty pool
        send_op(FN_ALLOC, 8'hFF, 4095);     // above pool
        send_op(FN_ALLOC, 8'h00, 1025);
        send_op(FN_ALLOC, 8'h01, 0);        // zero amount gets one unit
        send_op(FN_ALLOC, 8'h02, 1);
        send_op(FN_ALLOC, 8'h03, 3);
        send_op(FN_ALLOC, 8'hAA, 511);
        send_op(FN_ALLOC, 8'h55, 512);      // no space left for it
        send_op(FN_FREE, 8'h01, 2048);
        send_op(FN_FREE, 8'h02, 0);
        send_op(FN_FREE, 8'h03, 0);
        send_op(FN_FREE, 8'h03, 0);         // second release of same owner
        send_op(FN_FREE, 8'hAA, 0);         // back to one whole block
        send_op(FN_ALLOC, 8'h7F, 1024);     // whole pool exact fit
        send_op(FN_ALLOC, 8'h80, 1);
        send_op(FN_FREE, 8'h7F, 0);
        send_op(FN_ALLOC, 8'h10, 2730);
        send_op(FN_ALLOC, 8'h11, 1365);
    endtask

    // mostly small requests so the table grows deep; releases pick owners from a small set, now and then any owner
    task automatic test_random(int n);
        logic [7:0] own;
        int amt, r;
        for (int k = 0; k < n; k++) begin
            idle_en = !(k >= n / 3 && k < n / 2);
            r = $urandom_range(99);
            own = 8'($urandom_range(31));
            if (r < 3) begin
                amt = $urandom_range(4095);
                own = 8'($urandom);
            end else if (r < 58) begin
                amt = ($urandom_range(3) == 0) ? $urandom_range(1024) : $urandom_range(8);
            end else begin
                if ($urandom_range(9) == 0) own = 8'($urandom);
                amt = $urandom_range(4095);
            end
            send_op((r >= 58) ? FN_FREE : FN_ALLOC, own, amt);
        end
        idle_en = 1'b1;
    endtask

    // fill the table with single units to hit the entry limit, then drain it
    task automatic test_table_full();
        for (int k = 0; k < 275; k++) send_op(FN_ALLOC, k[7:0], $urandom_range(1));
        for (int k = 0; k < 275; k++) send_op(FN_FREE, k[7:0], 0);
    endtask

    initial begin
        table_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_edges();
        test_table_full();
        test_random(600);
        i_s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        $display("sent %0d requests/releases, checked %0d results, %0d with error codes",
                 n_sent, n_got, n_fail_codes);
        if (errors == 0 && grant_q.size() == 0)
            $display("[power_of_two_block_allocator] OK");
        else
            $display("[power_of_two_block_allocator] ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/ptba_pkg.sv
hdl/ptba_dp.sv
hdl/ptba_ctrl.sv
hdl/power_of_two_block_allocator.sv
tb/sv/tb.sv
